### sv/lpd_pkg.sv
// Shared types and constants for the length-prefixed message deframer.
`default_nettype none

package lpd_pkg;

  // Per-connection table depth and length header size
  localparam int CONNECTIONS  = 16;
  localparam int HEADER_BYTES = 4;

  // Derived widths
  localparam int LEN_W      = 8 * HEADER_BYTES;
  localparam int SEEN_W     = LEN_W + 1;
  localparam int CONN_IDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int HDR_IDX_W  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  // Received item: one raw byte tagged with its connection
  typedef struct packed {
    logic [3:0] conn;
    logic [7:0] rx_byte;
  } lpd_in_t;

  // Delivered item: payload byte or empty-message marker
  typedef struct packed {
    logic [3:0] out_conn;
    logic [7:0] payload_byte;
    logic       is_last;
    logic       is_empty;
  } lpd_out_t;

  // Result of one processing step
  typedef struct packed {
    logic     emit;
    lpd_out_t item;
  } lpd_res_t;

endpackage

`default_nettype wire

### sv/lpd_core.sv
// Per-connection byte counters, length capture and result decision.
`default_nettype none

module lpd_core
  import lpd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire lpd_in_t  item_i,
  output lpd_res_t      res_o
);

  logic [SEEN_W-1:0] seen_q [CONNECTIONS];
  logic [LEN_W-1:0]  len_q  [CONNECTIONS];

  logic [CONN_IDX_W-1:0] idx;
  logic                  in_range;
  logic [SEEN_W-1:0]     seen;
  logic [LEN_W-1:0]      len;
  logic                  in_hdr;
  logic [SEEN_W-1:0]     seen_inc;
  logic [SEEN_W-1:0]     body_lim;
  logic                  body_last;
  logic [LEN_W-1:0]      hdr_len;
  logic                  hdr_zero;
  logic [SEEN_W-1:0]     seen_d;
  logic [LEN_W-1:0]      len_d;

  // Look up the connection's state
  assign idx      = CONN_IDX_W'(item_i.conn);
  assign in_range = (int'(item_i.conn) < CONNECTIONS);
  assign seen     = seen_q[idx];
  assign len      = len_q[idx];
  assign in_hdr   = (seen < SEEN_W'(HEADER_BYTES));
  assign seen_inc = seen + SEEN_W'(1);

  // Final payload byte once the count reaches length plus header minus one
  assign body_lim  = {1'b0, len} + SEEN_W'(HEADER_BYTES - 1);
  assign body_last = (seen >= body_lim);

  // Merge the header byte into the length; the first header byte starts clean
  always_comb begin
    hdr_len = (seen == '0) ? '0 : len;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (seen[HDR_IDX_W-1:0] == HDR_IDX_W'(i)) begin
        hdr_len[8*i +: 8] = item_i.rx_byte;
      end
    end
  end

  assign hdr_zero = (seen_inc == SEEN_W'(HEADER_BYTES)) && (hdr_len == '0);

  // Next state and result
  always_comb begin
    res_o                    = '0;
    res_o.item.out_conn      = item_i.conn;
    seen_d                   = seen_inc;
    len_d                    = len;
    if (in_hdr) begin
      len_d = hdr_len;
      if (hdr_zero) begin
        seen_d              = '0;
        res_o.emit          = in_range;
        res_o.item.is_last  = 1'b1;
        res_o.item.is_empty = 1'b1;
      end
    end else begin
      res_o.emit              = in_range;
      res_o.item.payload_byte = item_i.rx_byte;
      if (body_last) begin
        seen_d             = '0;
        len_d              = '0;
        res_o.item.is_last = 1'b1;
      end
    end
  end

  // Update the connection's entry; out-of-range connections leave all state alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CONNECTIONS; i++) begin
        seen_q[i] <= '0;
        len_q[i]  <= '0;
      end
    end else if (step_i && in_range) begin
      seen_q[idx] <= seen_d;
      len_q[idx]  <= len_d;
    end
  end

  // A body count never passes the end of its message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && in_range && !in_hdr |-> seen <= body_lim)
    else $error("byte count ran past message end");

  // An empty marker only comes from a header byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.emit && res_o.item.is_empty |-> in_hdr && res_o.item.is_last)
    else $error("empty marker outside header completion");

  // Out-of-range connections give no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_range |-> !res_o.emit)
    else $error("result for unknown connection");

endmodule

`default_nettype wire

### sv/length_prefix_deframer_unit.sv
// Top level: input register, per-connection deframing step and result register.
// Input register, then result register: an accepted byte that gives an item raises out_valid_o.
// Throughput: one byte per cycle unless the result is stalled, any connection order, including
// back-to-back bytes on the same connection; the state table is read and written in one step.
// Reset (rst_ni low, asynchronous) clears all byte counts and captured lengths,
// so every connection starts with a fresh header; no items are held after reset.
`default_nettype none

module length_prefix_deframer_unit
  import lpd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire lpd_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lpd_out_t      out_item_o
);

  logic     in_vld_q;
  lpd_in_t  in_item_q;
  logic     out_vld_q;
  lpd_out_t out_item_q;
  logic     out_free;
  logic     advance;
  lpd_res_t res;

  // Advance the held item whenever the result register can take its outcome
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  lpd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.emit;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_item_q <= res.item;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  // Stall only while an item is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with nothing held");

  // A stalled result blocks the processing step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !advance)
    else $error("step advanced over a stalled result");

  // Empty markers carry no byte and close the message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_empty |->
      out_item_o.is_last && (out_item_o.payload_byte == 8'd0))
    else $error("malformed empty marker");

endmodule

`default_nettype wire

### verif/lpd_checker.sv
// Watches both channels of the deframer, predicts each delivered item and compares.
module lpd_checker
  import lpd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_stall_i,
  input  wire lpd_in_t  in_item_i,
  input  wire logic     out_valid_i,
  input  wire logic     out_stall_i,
  input  wire lpd_out_t out_item_i,
  output int            mismatch_count_o,
  output int            pending_o
);

  // Per-connection deframing state as the block should hold it
  logic [SEEN_W-1:0] seen_tbl [CONNECTIONS];
  logic [LEN_W-1:0]  len_tbl  [CONNECTIONS];

  // Delivered items still owed by the block, oldest first
  lpd_out_t owed_q [$];
  int       mismatches;

  // Advance one connection by one received byte; returns 1 when an item is delivered
  function automatic logic deframe(input lpd_in_t it, output lpd_out_t res);
    logic [SEEN_W-1:0] seen;
    logic [SEEN_W-1:0] body;
    int                c;
    c   = int'(it.conn);
    res = '0;
    if (c >= CONNECTIONS) return 1'b0;
    seen = seen_tbl[c];

    // Header byte: collect the little-endian length, first byte clears the old one
    if (seen < SEEN_W'(HEADER_BYTES)) begin
      if (seen == '0) len_tbl[c] = '0;
      len_tbl[c] = len_tbl[c] | (LEN_W'(it.rx_byte) << (8 * int'(seen)));
      seen = seen + 1'b1;
      if (seen == SEEN_W'(HEADER_BYTES) && len_tbl[c] == '0) begin
        // Zero-length message: one empty marker, then a fresh header
        seen_tbl[c]      = '0;
        res.out_conn     = it.conn;
        res.payload_byte = 8'h00;
        res.is_last      = 1'b1;
        res.is_empty     = 1'b1;
        return 1'b1;
      end
      seen_tbl[c] = seen;
      return 1'b0;
    end

    // Payload byte: pass it on, mark and restart on the final one
    seen             = seen + 1'b1;
    body             = seen - SEEN_W'(HEADER_BYTES);
    res.out_conn     = it.conn;
    res.payload_byte = it.rx_byte;
    if (body >= {1'b0, len_tbl[c]}) begin
      seen_tbl[c] = '0;
      len_tbl[c]  = '0;
      res.is_last = 1'b1;
    end else begin
      seen_tbl[c] = seen;
    end
    return 1'b1;
  endfunction

  // Count a bad delivery, print only the first few
  task automatic report(input string what, input lpd_out_t exp_item, input lpd_out_t act);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected conn=%0d byte=%02h last=%b empty=%b, got conn=%0d byte=%02h last=%b empty=%b",
               what, exp_item.out_conn, exp_item.payload_byte, exp_item.is_last,
               exp_item.is_empty, act.out_conn, act.payload_byte, act.is_last, act.is_empty);
    end
  endtask

  // Predict on accepted input, compare on accepted output
  always @(posedge clk_i or negedge rst_ni) begin : watch
    lpd_out_t res;
    lpd_out_t head;
    if (!rst_ni) begin
      for (int i = 0; i < CONNECTIONS; i++) begin
        seen_tbl[i] = '0;
        len_tbl[i]  = '0;
      end
      owed_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (deframe(in_item_i, res)) owed_q.push_back(res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          report("unexpected item", '0, out_item_i);
        end else begin
          head = owed_q.pop_front();
          if (head.out_conn !== out_item_i.out_conn ||
              head.payload_byte !== out_item_i.payload_byte ||
              head.is_last !== out_item_i.is_last ||
              head.is_empty !== out_item_i.is_empty) begin
            report("item mismatch", head, out_item_i);
          end
        end
      end
    end
    mismatch_count_o = mismatches;
    pending_o        = owed_q.size();
  end

endmodule

### verif/tb.sv
// Stimulus and verdict for the length-prefixed message deframer.
module tb
  import lpd_pkg::*;
();

  localparam int RANDOM_ITEMS = 630;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 200000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  lpd_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  lpd_out_t out_item;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;
  int mismatch_count;
  int pending_count;

  // Per-connection message builder: bytes sent of the current message and its length
  int             gen_pos [CONNECTIONS];
  logic [LEN_W-1:0] gen_len [CONNECTIONS];
  logic [3:0]     last_conn;

  always #6 clk = ~clk;

  length_prefix_deframer_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  lpd_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_item_i       (in_item),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_item_i      (out_item),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  function automatic logic [7:0] hdr_byte(input logic [LEN_W-1:0] len, input int k);
    return len[8*k +: 8];
  endfunction

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [3:0] c, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{conn: c, rx_byte: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send the next byte of a well-formed message on one connection
  task automatic send_next(input logic [3:0] c);
    logic [7:0] b;
    int         r;
    if (gen_pos[c] == 0) begin
      r = $urandom_range(99);
      if (r < 20)      gen_len[c] = '0;
      else if (r < 85) gen_len[c] = $urandom_range(6, 1);
      else if (r < 97) gen_len[c] = $urandom_range(40, 7);
      else             gen_len[c] = $urandom_range(255, 128);
    end
    if (gen_pos[c] < HEADER_BYTES) b = hdr_byte(gen_len[c], gen_pos[c]);
    else                           b = 8'($urandom);
    gen_pos[c]++;
    if (gen_pos[c] == HEADER_BYTES + int'(gen_len[c])) gen_pos[c] = 0;
    send_byte(c, b);
  endtask

  // Receiver: random stall, or one long hold-off on request
  initial begin
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int         r;
    logic [3:0] c;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    send_idle_pct = 12;
    recv_idle_pct = 63;
    last_conn     = '0;
    for (int i = 0; i < CONNECTIONS; i++) begin
      gen_pos[i] = 0;
      gen_len[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty message, then a one-byte message right behind it on the same connection
    for (int k = 0; k < HEADER_BYTES; k++) send_byte(4'd0, hdr_byte('0, k));
    for (int k = 0; k < HEADER_BYTES; k++) send_byte(4'd0, hdr_byte(LEN_W'(1), k));
    send_byte(4'd0, 8'hFF);

    // Largest length: payload bytes flow but never end
    for (int k = 0; k < HEADER_BYTES; k++) send_byte(4'd14, 8'hFF);
    send_byte(4'd14, 8'h00);
    send_byte(4'd14, 8'hFF);

    // Interleave a two-byte message with an empty one on another connection
    for (int k = 0; k < HEADER_BYTES; k++) begin
      send_byte(4'd3, hdr_byte(LEN_W'(2), k));
      send_byte(4'd9, hdr_byte('0, k));
    end
    send_byte(4'd3, 8'h00);
    send_byte(4'd3, 8'h80);

    // Random traffic: mostly well-formed messages, some stray bytes on two connections
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 12;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 4) begin
        send_byte(4'(14 + $urandom_range(1)), 8'($urandom));
      end else begin
        if (r < 35) c = last_conn;
        else        c = 4'($urandom_range(15));
        send_next(c);
        last_conn = c;
      end
    end
    in_valid <= 1'b0;

    // Drain and give the verdict
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("length_prefix_deframer_unit test passed");
    end else begin
      $display("length_prefix_deframer_unit test failed");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(LIMIT_CYCLES * 12);
    $display("length_prefix_deframer_unit test failed");
    $finish;
  end

endmodule
